// ===== src/tcpt_pkg.sv =====
// package: widths, cross-product index tables and stage count for the circumsphere test
`timescale 1ns / 1ps
package tcpt_pkg;

  // coordinate width of every input field
  localparam int COORD_BITS = 16;

  // derived widths
  localparam int DW   = COORD_BITS + 1;      // edge and query differences
  localparam int XW   = 2 * DW + 1;          // component of a x b
  localparam int NW   = 2 * DW + 2;          // squared norm of a difference vector
  localparam int DDW  = 2 * XW + 2;          // |a x b|^2
  localparam int MW   = NW + DW + 1;         // component of |a|^2 b - |b|^2 a
  localparam int ML   = MW / 2;              // low slice of m
  localparam int PPW  = MW + XW;             // partial product m slice times x
  localparam int NCW  = MW + XW + 1;         // component of the numerator vector
  localparam int DL   = DDW / 2;             // low slice of D
  localparam int DPW  = DDW - DL + NW + 1;   // partial product D slice times |w|^2
  localparam int NL   = NCW / 2;             // low slice of a numerator component
  localparam int RPW  = NCW - NL + DW + 1;   // partial product n slice times w
  localparam int WW   = DW + NCW + 3;        // final compare width

  // pipeline depth, input register through output register
  localparam int NST  = 10;

  // cyclic index tables for cross products
  localparam int unsigned N1 [3] = '{1, 2, 0};
  localparam int unsigned N2 [3] = '{2, 0, 1};

endpackage

// ===== src/triangle_circumsphere_point_test.sv =====
// top level: pipelined exact in-sphere test against the circumsphere of a 3d triangle
//
//   channel  | ports                                   | direction
//   input    | in_valid, in_ready, in_corner_*, in_query_* | into block
//   result   | out_valid, out_ready, out_inside_res, out_degenerate | out of block
//
// ten register stages; one transaction enters per cycle while the result side does not stall
// the throughput is set by the single pipeline enable: every stage advances together
// a stall on the result side freezes all stages and holds in_ready low; nothing is dropped
// rst_n (synchronous, active low) clears the stage valid bits only
// wide products are cut into slice partial products one stage ahead of their sums
`timescale 1ns / 1ps
module triangle_circumsphere_point_test
  import tcpt_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_corner_a_x,
  input  logic signed [COORD_BITS-1:0] in_corner_a_y,
  input  logic signed [COORD_BITS-1:0] in_corner_a_z,
  input  logic signed [COORD_BITS-1:0] in_corner_b_x,
  input  logic signed [COORD_BITS-1:0] in_corner_b_y,
  input  logic signed [COORD_BITS-1:0] in_corner_b_z,
  input  logic signed [COORD_BITS-1:0] in_corner_c_x,
  input  logic signed [COORD_BITS-1:0] in_corner_c_y,
  input  logic signed [COORD_BITS-1:0] in_corner_c_z,
  input  logic signed [COORD_BITS-1:0] in_query_x,
  input  logic signed [COORD_BITS-1:0] in_query_y,
  input  logic signed [COORD_BITS-1:0] in_query_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_inside_res,
  output logic                         out_degenerate
);

  logic                   en;
  logic [NST-1:0]         vld_r;
  logic [NST-1:0]         vld_nxt;

  // stage 1: differences
  logic signed [DW-1:0]   a1_r [3];
  logic signed [DW-1:0]   b1_r [3];
  logic signed [DW-1:0]   w1_r [3];
  // stage 2: raw products
  logic signed [2*DW-1:0] xp2_r [3];
  logic signed [2*DW-1:0] xq2_r [3];
  logic signed [2*DW-1:0] sa2_r [3];
  logic signed [2*DW-1:0] sb2_r [3];
  logic signed [2*DW-1:0] sw2_r [3];
  logic signed [DW-1:0]   a2_r [3];
  logic signed [DW-1:0]   b2_r [3];
  logic signed [DW-1:0]   w2_r [3];
  // stage 3: cross product and norms
  logic signed [XW-1:0]   x3_r [3];
  logic signed [NW-1:0]   na3_r;
  logic signed [NW-1:0]   nb3_r;
  logic signed [NW-1:0]   ww3_r;
  logic signed [DW-1:0]   a3_r [3];
  logic signed [DW-1:0]   b3_r [3];
  logic signed [DW-1:0]   w3_r [3];
  // stage 4: products for D and m
  logic signed [2*XW-1:0]   xx4_r [3];
  logic signed [NW+DW-1:0]  pb4_r [3];
  logic signed [NW+DW-1:0]  pa4_r [3];
  logic signed [XW-1:0]     x4_r [3];
  logic signed [NW-1:0]     ww4_r;
  logic signed [DW-1:0]     w4_r [3];
  // stage 5: D, m, degenerate flag
  logic signed [DDW-1:0]  d5_r;
  logic signed [MW-1:0]   m5_r [3];
  logic                   dg5_r;
  logic signed [XW-1:0]   x5_r [3];
  logic signed [NW-1:0]   ww5_r;
  logic signed [DW-1:0]   w5_r [3];
  // stage 6: sliced partial products
  logic signed [PPW-1:0]  pl1_6_r [3];
  logic signed [PPW-1:0]  ph1_6_r [3];
  logic signed [PPW-1:0]  pl2_6_r [3];
  logic signed [PPW-1:0]  ph2_6_r [3];
  logic signed [DPW-1:0]  dlo6_r;
  logic signed [DPW-1:0]  dhi6_r;
  logic                   dg6_r;
  logic signed [DW-1:0]   w6_r [3];
  // stage 7: numerator vector and left side
  logic signed [NCW-1:0]  n7_r [3];
  logic signed [WW-1:0]   lhs7_r;
  logic                   dg7_r;
  logic signed [DW-1:0]   w7_r [3];
  // stage 8: sliced products for w . n
  logic signed [RPW-1:0]  rl8_r [3];
  logic signed [RPW-1:0]  rh8_r [3];
  logic signed [WW-1:0]   lhs8_r;
  logic                   dg8_r;
  // stage 9: right side
  logic signed [WW-1:0]   rhs9_r;
  logic signed [WW-1:0]   lhs9_r;
  logic                   dg9_r;
  // stage 10: result register
  logic                   inside10_r;
  logic                   dg10_r;

  logic signed [DW-1:0]   ca [3];
  logic signed [DW-1:0]   cb [3];
  logic signed [DW-1:0]   cc [3];
  logic signed [DW-1:0]   cq [3];

  // whole pipeline advances when the result register is free or being taken
  assign en        = !vld_r[NST-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NST-1];
  assign out_inside_res = inside10_r;
  assign out_degenerate = dg10_r;

  assign ca[0] = DW'(in_corner_a_x);
  assign ca[1] = DW'(in_corner_a_y);
  assign ca[2] = DW'(in_corner_a_z);
  assign cb[0] = DW'(in_corner_b_x);
  assign cb[1] = DW'(in_corner_b_y);
  assign cb[2] = DW'(in_corner_b_z);
  assign cc[0] = DW'(in_corner_c_x);
  assign cc[1] = DW'(in_corner_c_y);
  assign cc[2] = DW'(in_corner_c_z);
  assign cq[0] = DW'(in_query_x);
  assign cq[1] = DW'(in_query_y);
  assign cq[2] = DW'(in_query_z);

  // valid bits travel with the data
  always_comb begin
    vld_nxt = {vld_r[NST-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        // stage 1: edge and query vectors relative to corner c
        a1_r[k] <= ca[k] - cc[k];
        b1_r[k] <= cb[k] - cc[k];
        w1_r[k] <= cq[k] - cc[k];

        // stage 2: cross and square products
        xp2_r[k] <= a1_r[N1[k]] * b1_r[N2[k]];
        xq2_r[k] <= a1_r[N2[k]] * b1_r[N1[k]];
        sa2_r[k] <= a1_r[k] * a1_r[k];
        sb2_r[k] <= b1_r[k] * b1_r[k];
        sw2_r[k] <= w1_r[k] * w1_r[k];
        a2_r[k]  <= a1_r[k];
        b2_r[k]  <= b1_r[k];
        w2_r[k]  <= w1_r[k];

        // stage 3: a x b
        x3_r[k] <= XW'(xp2_r[k]) - XW'(xq2_r[k]);
        a3_r[k] <= a2_r[k];
        b3_r[k] <= b2_r[k];
        w3_r[k] <= w2_r[k];

        // stage 4: squares of a x b, norm-weighted edges
        xx4_r[k] <= x3_r[k] * x3_r[k];
        pb4_r[k] <= na3_r * b3_r[k];
        pa4_r[k] <= nb3_r * a3_r[k];
        x4_r[k]  <= x3_r[k];
        w4_r[k]  <= w3_r[k];

        // stage 5: m = |a|^2 b - |b|^2 a
        m5_r[k] <= MW'(pb4_r[k]) - MW'(pa4_r[k]);
        x5_r[k] <= x4_r[k];
        w5_r[k] <= w4_r[k];

        // stage 6: m x (a x b) as sliced products
        pl1_6_r[k] <= PPW'($signed({1'b0, m5_r[N1[k]][ML-1:0]}) * x5_r[N2[k]]);
        ph1_6_r[k] <= PPW'($signed(m5_r[N1[k]][MW-1:ML]) * x5_r[N2[k]]);
        pl2_6_r[k] <= PPW'($signed({1'b0, m5_r[N2[k]][ML-1:0]}) * x5_r[N1[k]]);
        ph2_6_r[k] <= PPW'($signed(m5_r[N2[k]][MW-1:ML]) * x5_r[N1[k]]);
        w6_r[k]    <= w5_r[k];

        // stage 7: numerator components
        n7_r[k] <= (NCW'(ph1_6_r[k]) <<< ML) + NCW'(pl1_6_r[k])
                 - (NCW'(ph2_6_r[k]) <<< ML) - NCW'(pl2_6_r[k]);
        w7_r[k] <= w6_r[k];

        // stage 8: w . n as sliced products
        rl8_r[k] <= RPW'($signed({1'b0, n7_r[k][NL-1:0]}) * w7_r[k]);
        rh8_r[k] <= RPW'($signed(n7_r[k][NCW-1:NL]) * w7_r[k]);
      end

      // stage 3: squared norms
      na3_r <= NW'(sa2_r[0]) + NW'(sa2_r[1]) + NW'(sa2_r[2]);
      nb3_r <= NW'(sb2_r[0]) + NW'(sb2_r[1]) + NW'(sb2_r[2]);
      ww3_r <= NW'(sw2_r[0]) + NW'(sw2_r[1]) + NW'(sw2_r[2]);

      ww4_r <= ww3_r;

      // stage 5: D and collinear check
      d5_r  <= DDW'(xx4_r[0]) + DDW'(xx4_r[1]) + DDW'(xx4_r[2]);
      dg5_r <= (xx4_r[0] == '0) && (xx4_r[1] == '0) && (xx4_r[2] == '0);
      ww5_r <= ww4_r;

      // stage 6: D times |w|^2 as sliced products
      dlo6_r <= DPW'($signed({1'b0, d5_r[DL-1:0]}) * ww5_r);
      dhi6_r <= DPW'($signed(d5_r[DDW-1:DL]) * ww5_r);
      dg6_r  <= dg5_r;

      // stage 7: left side
      lhs7_r <= (WW'(dhi6_r) <<< DL) + WW'(dlo6_r);
      dg7_r  <= dg6_r;

      lhs8_r <= lhs7_r;
      dg8_r  <= dg7_r;

      // stage 9: right side
      rhs9_r <= (WW'(rh8_r[0]) <<< NL) + WW'(rl8_r[0])
              + (WW'(rh8_r[1]) <<< NL) + WW'(rl8_r[1])
              + (WW'(rh8_r[2]) <<< NL) + WW'(rl8_r[2]);
      lhs9_r <= lhs8_r;
      dg9_r  <= dg8_r;

      // stage 10: compare and result
      inside10_r <= !dg9_r && (lhs9_r <= rhs9_r);
      dg10_r     <= dg9_r;
    end
  end

`ifndef SYNTHESIS
  // a degenerate triangle never reports inside
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> !out_inside_res)
    else $error("degenerate result with inside set");

  // a stall freezes every stage valid bit
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  // an accepted transaction lands in the first stage
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted transaction lost at entry");

  // D times |w|^2 is never negative
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[6] |-> !lhs7_r[WW-1])
    else $error("left side went negative");
`endif

endmodule

// ===== dv/testbench.sv =====
// testbench for the pipelined exact in-sphere test against a triangle circumsphere
`timescale 1ns / 1ps
module testbench
  import tcpt_pkg::*;
();

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic in_sphere;
    logic degen;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t pt [12];
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_inside_res;
  logic out_degenerate;

  verdict_t verdict_q [$];
  int mismatches = 0;
  int checked = 0;
  int inside_seen = 0;
  int degen_seen = 0;
  int cycles = 0;
  int hold_cycles = 0;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  bit calm = 1'b0;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_LEN = 60;

  always #2 clk = ~clk;

  triangle_circumsphere_point_test uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_corner_a_x(pt[0]), .in_corner_a_y(pt[1]), .in_corner_a_z(pt[2]),
    .in_corner_b_x(pt[3]), .in_corner_b_y(pt[4]), .in_corner_b_z(pt[5]),
    .in_corner_c_x(pt[6]), .in_corner_c_y(pt[7]), .in_corner_c_z(pt[8]),
    .in_query_x(pt[9]), .in_query_y(pt[10]), .in_query_z(pt[11]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_inside_res(out_inside_res), .out_degenerate(out_degenerate)
  );

  initial for (int i = 0; i < 12; i++) pt[i] = '0;

  // exact circumsphere membership, no division
  function automatic verdict_t sphere_verdict(input coord_t p [12]);
    wide_t a [3], b [3], w [3], axb [3], m [3], n [3];
    wide_t d, na, nb, lhs, rhs;
    verdict_t v;
    for (int k = 0; k < 3; k++) begin
      a[k] = wide_t'(p[k]) - wide_t'(p[6+k]);
      b[k] = wide_t'(p[3+k]) - wide_t'(p[6+k]);
      w[k] = wide_t'(p[9+k]) - wide_t'(p[6+k]);
    end
    for (int k = 0; k < 3; k++)
      axb[k] = a[(k+1)%3] * b[(k+2)%3] - a[(k+2)%3] * b[(k+1)%3];
    d = axb[0]*axb[0] + axb[1]*axb[1] + axb[2]*axb[2];
    if (d == 0) begin
      v.in_sphere = 1'b0;
      v.degen = 1'b1;
      return v;
    end
    na = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
    nb = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
    for (int k = 0; k < 3; k++) m[k] = na * b[k] - nb * a[k];
    for (int k = 0; k < 3; k++)
      n[k] = m[(k+1)%3] * axb[(k+2)%3] - m[(k+2)%3] * axb[(k+1)%3];
    lhs = d * (w[0]*w[0] + w[1]*w[1] + w[2]*w[2]);
    rhs = w[0]*n[0] + w[1]*n[1] + w[2]*n[2];
    v.in_sphere = (lhs <= rhs);
    v.degen = 1'b0;
    return v;
  endfunction

  // offer one transaction and wait for acceptance
  task automatic send_triangle(input coord_t p [12]);
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    for (int i = 0; i < 12; i++) pt[i] <= p[i];
    in_valid <= 1'b1;
    verdict_q.push_back(sphere_verdict(p));
    do @(posedge clk); while (!in_ready);
  endtask

  // result side ready, with random idling and a long hold-off on request
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cycles <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 12);
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        verdict_t e;
        e = verdict_q.pop_front();
        checked++;
        inside_seen += out_inside_res;
        degen_seen += out_degenerate;
        if (e.in_sphere !== out_inside_res || e.degen !== out_degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: inside exp %b got %b, degenerate exp %b got %b",
                     e.in_sphere, out_inside_res, e.degen, out_degenerate);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic coord_t rand_coord(input int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(2*span) - span);
  endfunction

  // corner cases: extremes, coincident and collinear corners, query on the sphere
  task automatic test_directed();
    coord_t p [12];
    coord_t lim [4] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};
    for (int r = 0; r < 4; r++) begin
      for (int i = 0; i < 12; i++) p[i] = lim[(i + r) % 4];
      send_triangle(p);
    end
    for (int i = 0; i < 12; i++) p[i] = 16'sh8000;
    send_triangle(p);
    for (int i = 0; i < 12; i++) p[i] = 16'sh7fff;
    send_triangle(p);
    // a corner of the triangle as query: on the sphere
    p = '{100, 0, 0, 0, 100, 0, 0, 0, 0, 100, 0, 0};
    send_triangle(p);
    // center point and far point
    p = '{100, 0, 0, 0, 100, 0, 0, 0, 0, 50, 50, 0};
    send_triangle(p);
    p = '{100, 0, 0, 0, 100, 0, 0, 0, 0, -32768, 32767, -32768};
    send_triangle(p);
    // collinear and coincident corners
    p = '{1, 2, 3, 2, 4, 6, 3, 6, 9, 0, 0, 0};
    send_triangle(p);
    p = '{5, 5, 5, 5, 5, 5, 9, 9, 9, 5, 5, 5};
    send_triangle(p);
    // widest triangle with opposite extremes
    p = '{32767, -32768, 32767, -32768, 32767, -32768, -32768, -32768, 32767,
          32767, 32767, 32767};
    send_triangle(p);
    p = '{-32768, 0, 0, 32767, 0, 0, 0, 32767, -32768, 0, 0, 32767};
    send_triangle(p);
  endtask

  // random triangles; query near the sphere often, plus collinear ones
  task automatic test_random(input int count);
    coord_t p [12];
    int span;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(3))
        0: span = 0;
        1: span = 300;
        default: span = 4000;
      endcase
      for (int i = 0; i < 12; i++) p[i] = rand_coord(span);
      if ($urandom_range(9) == 0) begin
        // collinear: b = c + k (a - c)
        for (int k = 0; k < 3; k++) begin
          p[k] = rand_coord(100);
          p[6+k] = rand_coord(100);
          p[3+k] = coord_t'(p[6+k] + 3 * (p[k] - p[6+k]));
        end
      end else if ($urandom_range(3) == 0) begin
        // query near a corner so both outcomes show up
        for (int k = 0; k < 3; k++) p[9+k] = p[k] + coord_t'($urandom_range(4) - 2);
      end
      send_triangle(p);
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_req = !hold_req;
    test_random(30);
  endtask

  // stretch with no idling on either side
  task automatic test_full_rate();
    calm = 1'b1;
    test_random(80);
    calm = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(150);
    test_backpressure();
    test_full_rate();
    test_random(140);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (NST + 10) @(posedge clk);
    $display("checked %0d results: %0d inside, %0d degenerate", checked, inside_seen,
             degen_seen);
    $display("covered extremes, collinear corners, back-pressure and full-rate streaming");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
